FILE: src/tmcs_pkg.sv
// shared types, widths and the format table for the mip chain size block
package tmcs_pkg;

  localparam int unsigned FMT_W   = 16;
  localparam int unsigned LVL_W   = 5;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned BPP_W   = 5;
  localparam int unsigned COMPS_W = 3;
  localparam int unsigned PIPE_FRONT = 4;  // input stage plus three multiply stages

  typedef struct packed {
    logic [BPP_W-1:0]   bpp;
    logic [COMPS_W-1:0] comps;
  } fmt_info_t;

  // internal format decode, unknown codes fall to four bytes and four channels
  function automatic fmt_info_t fmt_lookup(input logic [FMT_W-1:0] code);
    fmt_info_t info;
    info.bpp   = BPP_W'(4);
    info.comps = COMPS_W'(4);
    unique case (code) inside
      16'h8229, 16'h8F94, 16'h8231, 16'h8232, 16'h8D48: begin
        info.bpp = BPP_W'(1);  info.comps = COMPS_W'(1);
      end
      16'h822D, 16'h8233, 16'h8234, 16'h81A5: begin
        info.bpp = BPP_W'(2);  info.comps = COMPS_W'(1);
      end
      16'h81A6: begin
        info.bpp = BPP_W'(3);  info.comps = COMPS_W'(1);
      end
      16'h822E, 16'h8235, 16'h8236, 16'h8CAC: begin
        info.bpp = BPP_W'(4);  info.comps = COMPS_W'(1);
      end
      16'h822B, 16'h8F95, 16'h8237, 16'h8238: begin
        info.bpp = BPP_W'(2);  info.comps = COMPS_W'(2);
      end
      16'h822F, 16'h8239, 16'h823A, 16'h88F0: begin
        info.bpp = BPP_W'(4);  info.comps = COMPS_W'(2);
      end
      16'h8230, 16'h823B, 16'h823C, 16'h8CAD: begin
        info.bpp = BPP_W'(8);  info.comps = COMPS_W'(2);
      end
      16'h8051, 16'h8C41, 16'h8F96, 16'h8D8F, 16'h8D7D: begin
        info.bpp = BPP_W'(3);  info.comps = COMPS_W'(3);
      end
      16'h8C3A, 16'h8C3D: begin
        info.bpp = BPP_W'(4);  info.comps = COMPS_W'(3);
      end
      16'h881B, 16'h8D89, 16'h8D77: begin
        info.bpp = BPP_W'(6);  info.comps = COMPS_W'(3);
      end
      16'h8815, 16'h8D83, 16'h8D71: begin
        info.bpp = BPP_W'(12); info.comps = COMPS_W'(3);
      end
      16'h8058, 16'h8C43, 16'h8F97, 16'h8D8E, 16'h8D7C, 16'h8059, 16'h906F: begin
        info.bpp = BPP_W'(4);  info.comps = COMPS_W'(4);
      end
      16'h8057, 16'h8056: begin
        info.bpp = BPP_W'(2);  info.comps = COMPS_W'(4);
      end
      16'h881A, 16'h8D88, 16'h8D76: begin
        info.bpp = BPP_W'(8);  info.comps = COMPS_W'(4);
      end
      16'h8814, 16'h8D82, 16'h8D70: begin
        info.bpp = BPP_W'(16); info.comps = COMPS_W'(4);
      end
      default: begin
        info.bpp = BPP_W'(4);  info.comps = COMPS_W'(4);
      end
    endcase
    return info;
  endfunction

endpackage

FILE: src/texture_mip_chain_size_core.sv
// top level of the texture mip chain byte size calculator
//
// takes one texture descriptor per transfer (format code, base width, height,
// depth and level count) and returns one result per descriptor: the byte size
// of the whole mip chain modulo 2^32, plus the format's bytes per texel and
// channel count (unknown formats report 4 and 4). zero dimensions count as
// one, each level halves every dimension with a floor of one, a level count
// above MAX_LEVELS is clamped and a count of zero gives zero bytes.
// the block is a fully pipelined datapath: one descriptor can be accepted in
// every cycle while the output side takes results or the pipe has room. each
// result passes the input stage, the per-level lanes, each a chain of three
// registered multiplies (width*height, *depth, *bytes per texel), and then
// the registered adder tree that folds the lanes into the total. every stage
// carries a valid bit and stalls only when the stage after it is full, so a
// held result does not block new transfers while the pipe has empty slots.
// the block keeps no state between items and needs no warm-up after reset.
module texture_mip_chain_size_core import tmcs_pkg::*; #(
  parameter int unsigned MAX_LEVELS = 16,
  parameter int unsigned DIM_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [FMT_W-1:0]    format_code_i,
  input  logic [DIM_BITS-1:0] tex_width_i,
  input  logic [DIM_BITS-1:0] tex_height_i,
  input  logic [DIM_BITS-1:0] tex_depth_i,
  input  logic [LVL_W-1:0]    level_count_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SUM_W-1:0]    total_bytes_o,
  output logic [BPP_W-1:0]    bytes_per_texel_o,
  output logic [COMPS_W-1:0]  component_count_o
);

  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
  localparam int unsigned DEPTH = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 0;
  localparam int unsigned EN_W  = (DEPTH > 0) ? DEPTH : 1;
  localparam int unsigned NSTG  = PIPE_FRONT + DEPTH;

  // stage enables: a stage loads when it is empty or its item moves on
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] v_q, v_d;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_valid_i : v_q[0];
    for (int k = 1; k < NSTG; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_ready_o = en[0];

  // input stage: format decode, dimension clamp and level count saturation
  fmt_info_t           fmt_d;
  logic [CNT_W-1:0]    lvl_d;
  logic [DIM_BITS-1:0] w0_d, h0_d, d0_d;

  logic [CNT_W-1:0]    lvl_q;
  logic [DIM_BITS-1:0] w0_q, h0_q, d0_q;
  logic [BPP_W-1:0]    bpp_q   [NSTG];
  logic [COMPS_W-1:0]  comps_q [NSTG];

  assign fmt_d = fmt_lookup(format_code_i);
  assign lvl_d = (32'(level_count_i) > MAX_LEVELS) ? CNT_W'(MAX_LEVELS)
                                                   : CNT_W'(level_count_i);
  assign w0_d  = (tex_width_i  == '0) ? DIM_BITS'(1) : tex_width_i;
  assign h0_d  = (tex_height_i == '0) ? DIM_BITS'(1) : tex_height_i;
  assign d0_d  = (tex_depth_i  == '0) ? DIM_BITS'(1) : tex_depth_i;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lvl_q      <= lvl_d;
      w0_q       <= w0_d;
      h0_q       <= h0_d;
      d0_q       <= d0_d;
      bpp_q[0]   <= fmt_d.bpp;
      comps_q[0] <= fmt_d.comps;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        bpp_q[k]   <= bpp_q[k-1];
        comps_q[k] <= comps_q[k-1];
      end
    end
  end

  // one lane per mip level, lanes past the level count contribute zero
  logic [SUM_W-1:0] lane_prod [MAX_LEVELS];

  for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_lane
    tmcs_lane #(
      .LEVEL    (l),
      .DIM_BITS (DIM_BITS),
      .CNT_W    (CNT_W)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en[3:1]),
      .w_i    (w0_q),
      .h_i    (h0_q),
      .d_i    (d0_q),
      .lvl_i  (lvl_q),
      .bpp_i  (bpp_q[2]),
      .prod_o (lane_prod[l])
    );
  end

  // adder tree, its stages follow the lane stages
  logic [EN_W-1:0] tree_en;

  if (DEPTH > 0) begin : g_tree_en
    assign tree_en = en[NSTG-1:PIPE_FRONT];
  end else begin : g_no_tree_en
    assign tree_en = en[NSTG-1];
  end

  tmcs_sum_tree #(
    .N (MAX_LEVELS)
  ) u_sum_tree (
    .clk_i  (clk_i),
    .en_i   (tree_en),
    .leaf_i (lane_prod),
    .sum_o  (total_bytes_o)
  );

  assign out_valid_o       = v_q[NSTG-1];
  assign bytes_per_texel_o = bpp_q[NSTG-1];
  assign component_count_o = comps_q[NSTG-1];

  // format fields of a result are always in the legal range
  a_bpp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bytes_per_texel_o != '0) && (bytes_per_texel_o <= BPP_W'(16)))
    else $error("bytes per texel out of range");

  a_comps_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (component_count_o != '0) && (component_count_o <= COMPS_W'(4)))
    else $error("component count out of range");

  // an item only enters the pipe through an input transfer
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v_q[0]) |-> $past(in_valid_i && in_ready_o))
    else $error("first stage became valid without an input transfer");

  // a blocked first stage keeps its item and its sideband
  a_hold_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !en[0] |=> v_q[0] && $stable(bpp_q[0]) && $stable(lvl_q))
    else $error("first stage lost its item while stalled");

  // after an output transfer a new result comes only from the stage before
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o || $past(v_q[NSTG-2]))
    else $error("result repeated after its transfer");

endmodule

FILE: src/tmcs_lane.sv
// one mip level lane: three pipelined multiplies giving that level's byte size
module tmcs_lane import tmcs_pkg::*; #(
  parameter int unsigned LEVEL    = 0,
  parameter int unsigned DIM_BITS = 16,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                clk_i,
  input  logic [2:0]          en_i,
  input  logic [DIM_BITS-1:0] w_i,
  input  logic [DIM_BITS-1:0] h_i,
  input  logic [DIM_BITS-1:0] d_i,
  input  logic [CNT_W-1:0]    lvl_i,
  input  logic [BPP_W-1:0]    bpp_i,
  output logic [SUM_W-1:0]    prod_o
);

  function automatic logic [DIM_BITS-1:0] lvl_dim(input logic [DIM_BITS-1:0] base);
    logic [DIM_BITS-1:0] s;
    s = base >> LEVEL;
    return (s == '0) ? DIM_BITS'(1) : s;
  endfunction

  logic [DIM_BITS-1:0] w_l, h_l, d_l;
  logic [SUM_W-1:0]    wh_d, whd_d, prod_d;
  logic                act_d;

  logic [SUM_W-1:0]    wh_q, whd_q, prod_q;
  logic [DIM_BITS-1:0] d1_q;
  logic                act1_q, act2_q;

  assign w_l    = lvl_dim(w_i);
  assign h_l    = lvl_dim(h_i);
  assign d_l    = lvl_dim(d_i);
  assign act_d  = (32'(lvl_i) > LEVEL);
  assign wh_d   = SUM_W'(w_l) * SUM_W'(h_l);
  assign whd_d  = wh_q * SUM_W'(d1_q);
  assign prod_d = act2_q ? (whd_q * SUM_W'(bpp_i)) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      wh_q   <= wh_d;
      d1_q   <= d_l;
      act1_q <= act_d;
    end
    if (en_i[1]) begin
      whd_q  <= whd_d;
      act2_q <= act1_q;
    end
    if (en_i[2]) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: src/tmcs_sum_tree.sv
// registered adder tree summing the per-level byte sizes
module tmcs_sum_tree import tmcs_pkg::*; #(
  parameter int unsigned N     = 16,
  parameter int unsigned DEPTH = (N > 1) ? $clog2(N) : 0,
  parameter int unsigned EN_W  = (DEPTH > 0) ? DEPTH : 1
) (
  input  logic             clk_i,
  input  logic [EN_W-1:0]  en_i,
  input  logic [SUM_W-1:0] leaf_i [N],
  output logic [SUM_W-1:0] sum_o
);

  localparam int unsigned NP = 1 << DEPTH;

  logic [SUM_W-1:0] leaf_w [NP];

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign leaf_w[j] = leaf_i[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  if (DEPTH == 0) begin : g_flat
    assign sum_o = leaf_w[0];
  end else begin : g_tree
    // heap order: node i has children 2i+1 and 2i+2, leaves follow the NP-1 nodes
    logic [SUM_W-1:0] node_q [NP-1];

    for (genvar i = 0; i < NP - 1; i++) begin : g_node
      localparam int unsigned LV = $clog2(i + 2) - 1;
      localparam int unsigned CL = 2 * i + 1;
      localparam int unsigned CR = 2 * i + 2;
      logic [SUM_W-1:0] a, b;
      if (CL >= NP - 1) begin : g_from_leaf
        assign a = leaf_w[CL-(NP-1)];
        assign b = leaf_w[CR-(NP-1)];
      end else begin : g_from_node
        assign a = node_q[CL];
        assign b = node_q[CR];
      end
      always_ff @(posedge clk_i) begin
        if (en_i[DEPTH-1-LV]) begin
          node_q[i] <= a + b;
        end
      end
    end

    assign sum_o = node_q[0];
  end

endmodule

FILE: sim/tb_top.sv
// testbench for the texture mip chain byte size calculator
module tb_top import tmcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEVELS = 16;
  localparam int unsigned DIM_BITS   = 16;

  // random part and pressure points
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned DRAIN_AT     = 450;  // sender waits for an empty pipe here
  localparam int unsigned HOLD_AT      = 600;  // result count that starts the long hold-off
  localparam int unsigned HOLD_LEN     = 150;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS  = 10;

  // internal format codes
  localparam logic [FMT_W-1:0] FMT_R8 = 16'h8229, FMT_R8_SNORM = 16'h8F94;
  localparam logic [FMT_W-1:0] FMT_R8I = 16'h8231, FMT_R8UI = 16'h8232;
  localparam logic [FMT_W-1:0] FMT_R16F = 16'h822D, FMT_R16I = 16'h8233;
  localparam logic [FMT_W-1:0] FMT_R16UI = 16'h8234, FMT_R32F = 16'h822E;
  localparam logic [FMT_W-1:0] FMT_R32I = 16'h8235, FMT_R32UI = 16'h8236;
  localparam logic [FMT_W-1:0] FMT_RG8 = 16'h822B, FMT_RG8_SNORM = 16'h8F95;
  localparam logic [FMT_W-1:0] FMT_RG8I = 16'h8237, FMT_RG8UI = 16'h8238;
  localparam logic [FMT_W-1:0] FMT_RG16F = 16'h822F, FMT_RG16I = 16'h8239;
  localparam logic [FMT_W-1:0] FMT_RG16UI = 16'h823A, FMT_RG32F = 16'h8230;
  localparam logic [FMT_W-1:0] FMT_RG32I = 16'h823B, FMT_RG32UI = 16'h823C;
  localparam logic [FMT_W-1:0] FMT_RGB8 = 16'h8051, FMT_SRGB8 = 16'h8C41;
  localparam logic [FMT_W-1:0] FMT_RGB8_SNORM = 16'h8F96, FMT_RGB8I = 16'h8D8F;
  localparam logic [FMT_W-1:0] FMT_RGB8UI = 16'h8D7D, FMT_R11F_G11F_B10F = 16'h8C3A;
  localparam logic [FMT_W-1:0] FMT_RGB9_E5 = 16'h8C3D, FMT_RGB16F = 16'h881B;
  localparam logic [FMT_W-1:0] FMT_RGB16I = 16'h8D89, FMT_RGB16UI = 16'h8D77;
  localparam logic [FMT_W-1:0] FMT_RGB32F = 16'h8815, FMT_RGB32I = 16'h8D83;
  localparam logic [FMT_W-1:0] FMT_RGB32UI = 16'h8D71, FMT_RGBA8 = 16'h8058;
  localparam logic [FMT_W-1:0] FMT_SRGB8_ALPHA8 = 16'h8C43, FMT_RGBA8_SNORM = 16'h8F97;
  localparam logic [FMT_W-1:0] FMT_RGBA8I = 16'h8D8E, FMT_RGBA8UI = 16'h8D7C;
  localparam logic [FMT_W-1:0] FMT_RGB5_A1 = 16'h8057, FMT_RGBA4 = 16'h8056;
  localparam logic [FMT_W-1:0] FMT_RGB10_A2 = 16'h8059, FMT_RGB10_A2UI = 16'h906F;
  localparam logic [FMT_W-1:0] FMT_RGBA16F = 16'h881A, FMT_RGBA16I = 16'h8D88;
  localparam logic [FMT_W-1:0] FMT_RGBA16UI = 16'h8D76, FMT_RGBA32F = 16'h8814;
  localparam logic [FMT_W-1:0] FMT_RGBA32I = 16'h8D82, FMT_RGBA32UI = 16'h8D70;
  localparam logic [FMT_W-1:0] FMT_DEPTH16 = 16'h81A5, FMT_DEPTH24 = 16'h81A6;
  localparam logic [FMT_W-1:0] FMT_DEPTH32F = 16'h8CAC, FMT_STENCIL8 = 16'h8D48;
  localparam logic [FMT_W-1:0] FMT_DEPTH24_STENCIL8 = 16'h88F0;
  localparam logic [FMT_W-1:0] FMT_DEPTH32F_STENCIL8 = 16'h8CAD;

  typedef struct packed {
    logic [FMT_W-1:0]   code;
    logic [BPP_W-1:0]   bpp;
    logic [COMPS_W-1:0] comps;
  } texel_format_t;

  localparam int unsigned NUM_FORMATS = 54;
  localparam texel_format_t TEXEL_FORMATS [NUM_FORMATS] = '{
    '{FMT_R8, 5'd1, 3'd1}, '{FMT_R8_SNORM, 5'd1, 3'd1}, '{FMT_R8I, 5'd1, 3'd1},
    '{FMT_R8UI, 5'd1, 3'd1}, '{FMT_R16F, 5'd2, 3'd1}, '{FMT_R16I, 5'd2, 3'd1},
    '{FMT_R16UI, 5'd2, 3'd1}, '{FMT_R32F, 5'd4, 3'd1}, '{FMT_R32I, 5'd4, 3'd1},
    '{FMT_R32UI, 5'd4, 3'd1}, '{FMT_RG8, 5'd2, 3'd2}, '{FMT_RG8_SNORM, 5'd2, 3'd2},
    '{FMT_RG8I, 5'd2, 3'd2}, '{FMT_RG8UI, 5'd2, 3'd2}, '{FMT_RG16F, 5'd4, 3'd2},
    '{FMT_RG16I, 5'd4, 3'd2}, '{FMT_RG16UI, 5'd4, 3'd2}, '{FMT_RG32F, 5'd8, 3'd2},
    '{FMT_RG32I, 5'd8, 3'd2}, '{FMT_RG32UI, 5'd8, 3'd2}, '{FMT_RGB8, 5'd3, 3'd3},
    '{FMT_SRGB8, 5'd3, 3'd3}, '{FMT_RGB8_SNORM, 5'd3, 3'd3}, '{FMT_RGB8I, 5'd3, 3'd3},
    '{FMT_RGB8UI, 5'd3, 3'd3}, '{FMT_R11F_G11F_B10F, 5'd4, 3'd3},
    '{FMT_RGB9_E5, 5'd4, 3'd3}, '{FMT_RGB16F, 5'd6, 3'd3}, '{FMT_RGB16I, 5'd6, 3'd3},
    '{FMT_RGB16UI, 5'd6, 3'd3}, '{FMT_RGB32F, 5'd12, 3'd3}, '{FMT_RGB32I, 5'd12, 3'd3},
    '{FMT_RGB32UI, 5'd12, 3'd3}, '{FMT_RGBA8, 5'd4, 3'd4},
    '{FMT_SRGB8_ALPHA8, 5'd4, 3'd4}, '{FMT_RGBA8_SNORM, 5'd4, 3'd4},
    '{FMT_RGBA8I, 5'd4, 3'd4}, '{FMT_RGBA8UI, 5'd4, 3'd4}, '{FMT_RGB5_A1, 5'd2, 3'd4},
    '{FMT_RGBA4, 5'd2, 3'd4}, '{FMT_RGB10_A2, 5'd4, 3'd4}, '{FMT_RGB10_A2UI, 5'd4, 3'd4},
    '{FMT_RGBA16F, 5'd8, 3'd4}, '{FMT_RGBA16I, 5'd8, 3'd4}, '{FMT_RGBA16UI, 5'd8, 3'd4},
    '{FMT_RGBA32F, 5'd16, 3'd4}, '{FMT_RGBA32I, 5'd16, 3'd4},
    '{FMT_RGBA32UI, 5'd16, 3'd4}, '{FMT_DEPTH16, 5'd2, 3'd1}, '{FMT_DEPTH24, 5'd3, 3'd1},
    '{FMT_DEPTH32F, 5'd4, 3'd1}, '{FMT_STENCIL8, 5'd1, 3'd1},
    '{FMT_DEPTH24_STENCIL8, 5'd4, 3'd2}, '{FMT_DEPTH32F_STENCIL8, 5'd8, 3'd2}
  };

  // one texture descriptor plus how the sender paces it
  typedef struct {
    logic [FMT_W-1:0]    fmt;
    logic [DIM_BITS-1:0] w;
    logic [DIM_BITS-1:0] h;
    logic [DIM_BITS-1:0] d;
    logic [LVL_W-1:0]    levels;
    int unsigned         gap;
    bit                  drain_first;
  } tex_desc_t;

  typedef struct packed {
    logic [SUM_W-1:0]   total;
    logic [BPP_W-1:0]   bpp;
    logic [COMPS_W-1:0] comps;
  } chain_size_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [FMT_W-1:0]    fmt_code = '0;
  logic [DIM_BITS-1:0] tex_w    = '0;
  logic [DIM_BITS-1:0] tex_h    = '0;
  logic [DIM_BITS-1:0] tex_d    = '0;
  logic [LVL_W-1:0]    levels   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [SUM_W-1:0]    total_bytes;
  logic [BPP_W-1:0]    bpp_out;
  logic [COMPS_W-1:0]  comps_out;

  tex_desc_t   desc_q[$];      // descriptors not yet offered
  chain_size_t chain_size_q[$];  // predicted results in transfer order
  int unsigned desc_total = 0;
  int unsigned send_gap   = 0;
  int unsigned backlog_n  = 0;   // outstanding predictions, as of the last edge
  int unsigned taken_n    = 0;   // input transfers so far
  int unsigned fault_n    = 0;
  int unsigned idle_cycles = 0;

  texture_mip_chain_size_core #(
    .MAX_LEVELS(MAX_LEVELS),
    .DIM_BITS  (DIM_BITS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .format_code_i    (fmt_code),
    .tex_width_i      (tex_w),
    .tex_height_i     (tex_h),
    .tex_depth_i      (tex_d),
    .level_count_i    (levels),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .total_bytes_o    (total_bytes),
    .bytes_per_texel_o(bpp_out),
    .component_count_o(comps_out)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // byte size of a whole mip chain, 32-bit wraparound at every step
  function automatic chain_size_t mip_chain_bytes(input tex_desc_t dsc);
    chain_size_t res;
    logic [31:0] w, h, d, lvl_bytes;
    int unsigned lvl_n;
    res.bpp   = BPP_W'(4);
    res.comps = COMPS_W'(4);
    for (int i = 0; i < NUM_FORMATS; i++) begin
      if (TEXEL_FORMATS[i].code == dsc.fmt) begin
        res.bpp   = TEXEL_FORMATS[i].bpp;
        res.comps = TEXEL_FORMATS[i].comps;
      end
    end
    w = (dsc.w == 0) ? 32'd1 : 32'(dsc.w);
    h = (dsc.h == 0) ? 32'd1 : 32'(dsc.h);
    d = (dsc.d == 0) ? 32'd1 : 32'(dsc.d);
    lvl_n = (dsc.levels > MAX_LEVELS) ? MAX_LEVELS : dsc.levels;
    res.total = '0;
    for (int l = 0; l < lvl_n; l++) begin
      lvl_bytes = w * h;
      lvl_bytes = lvl_bytes * d;
      lvl_bytes = lvl_bytes * 32'(res.bpp);
      res.total = res.total + lvl_bytes;
      w = (w > 1) ? (w >> 1) : 32'd1;
      h = (h > 1) ? (h >> 1) : 32'd1;
      d = (d > 1) ? (d >> 1) : 32'd1;
    end
    return res;
  endfunction

  task automatic report_fault(input string what, input logic [31:0] want, got);
    fault_n++;
    if (fault_n <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
  endtask

  task automatic add_desc(input logic [FMT_W-1:0] fmt, input logic [DIM_BITS-1:0] w, h, d,
                          input logic [LVL_W-1:0] lv);
    tex_desc_t dsc;
    dsc.fmt         = fmt;
    dsc.w           = w;
    dsc.h           = h;
    dsc.d           = d;
    dsc.levels      = lv;
    dsc.gap         = $urandom_range(0, 8);
    dsc.drain_first = 1'b0;
    desc_q.push_back(dsc);
  endtask

  // mostly small textures, with zeros, powers of two and full-range sizes mixed in
  function automatic logic [DIM_BITS-1:0] random_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return DIM_BITS'(1) << $urandom_range(0, DIM_BITS - 1);
      3, 4:    return DIM_BITS'($urandom);
      default: return DIM_BITS'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [FMT_W-1:0] random_fmt();
    logic [FMT_W-1:0] code;
    code = TEXEL_FORMATS[$urandom_range(0, NUM_FORMATS - 1)].code;
    case ($urandom_range(0, 9))
      6:       return FMT_W'($urandom);
      7:       return code ^ (FMT_W'(1) << $urandom_range(0, FMT_W - 1));  // near miss
      8:       return $urandom_range(0, 1) ? '1 : '0;
      default: return code;
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] random_levels();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2, 3:    return LVL_W'($urandom_range(MAX_LEVELS + 1, 31));  // saturates
      4, 5:    return LVL_W'(MAX_LEVELS);
      default: return LVL_W'($urandom_range(1, MAX_LEVELS - 1));
    endcase
  endfunction

  // stimulus, then wait for the pipe to empty and report
  initial begin
    // directed: field extremes, every bytes-per-texel class, corner cases
    add_desc('0, '0, '0, '0, '0);
    add_desc('1, '1, '1, '1, '1);
    add_desc(FMT_RGBA32F, '1, '1, '1, LVL_W'(MAX_LEVELS));
    add_desc(FMT_R8, 16'd1, 16'd1, 16'd1, 5'd1);
    add_desc(FMT_RGB8I, 16'd7, 16'd5, 16'd3, 5'd4);
    add_desc(FMT_RGB8UI, 16'd640, 16'd480, 16'd1, 5'd10);
    add_desc(FMT_RGBA8, '0, 16'd256, '0, 5'd17);
    add_desc(FMT_RGB32F, 16'd1024, 16'd1, 16'd6, LVL_W'(MAX_LEVELS));
    add_desc(FMT_RG32F, 16'd3, 16'd1000, 16'd2, 5'd5);
    add_desc(FMT_RGB16F, 16'd512, 16'd512, 16'd512, 5'd10);
    add_desc(FMT_DEPTH24_STENCIL8, 16'd4096, 16'd4096, 16'd1, 5'd13);
    add_desc(FMT_DEPTH24, 16'd33, 16'd17, 16'd9, 5'd6);
    add_desc(FMT_R16F, '1, '0, 16'd1, 5'd2);
    add_desc(FMT_RGBA4, 16'd1, '1, 16'd1, 5'd3);
    add_desc(FMT_RGB10_A2UI, 16'd2, 16'd2, '1, LVL_W'(MAX_LEVELS));
    add_desc(FMT_STENCIL8, 16'd1, 16'd1, 16'd1, '0);
    add_desc(FMT_R8 - 16'd1, 16'd8, 16'd8, 16'd8, 5'd4);
    add_desc(FMT_DEPTH32F_STENCIL8, 16'd8, 16'd8, 16'd2, 5'd1);
    add_desc(FMT_R32UI, 16'h8000, 16'd1, 16'd1, 5'd1);
    add_desc(FMT_RGBA16F, 16'd100, 16'd100, 16'd100, 5'd15);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_desc(random_fmt(), random_dim(), random_dim(), random_dim(), random_levels());
      // back-to-back stretches, one of them feeding the long output hold-off
      if ((i >= 200 && i < 320) || (i >= 560 && i < 720))
        desc_q[desc_q.size() - 1].gap = 0;
      if (i == 0 || i == DRAIN_AT)
        desc_q[desc_q.size() - 1].drain_first = 1'b1;
    end
    desc_total = desc_q.size();

    while (taken_n != desc_total || backlog_n != 0) @(posedge clk_i);
    repeat (4 + $clog2(MAX_LEVELS) + 12) @(posedge clk_i);
    if (chain_size_q.size() != 0)
      report_fault("missing results", 32'(chain_size_q.size()), 32'd0);

    if (fault_n == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // sender: offers descriptors in order, idles the drawn gap after each transfer
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_ready) begin
      // hold valid and payload until the transfer
    end else if (send_gap != 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (desc_q.size() != 0 &&
                 !(desc_q[0].drain_first && (in_valid || backlog_n != 0))) begin
      in_valid <= 1'b1;
      fmt_code <= desc_q[0].fmt;
      tex_w    <= desc_q[0].w;
      tex_h    <= desc_q[0].h;
      tex_d    <= desc_q[0].d;
      levels   <= desc_q[0].levels;
      send_gap <= desc_q[0].gap;
      void'(desc_q.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall after each result, one long hold-off, a stall-free window
  int unsigned results_seen = 0;
  int unsigned recv_stall   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        recv_stall = (results_seen >= 150 && results_seen < 260) ? 0 : $urandom_range(0, 8);
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on each input transfer, checks each output transfer
  chain_size_t want;
  tex_desc_t   seen_desc;

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (chain_size_q.size() == 0) begin
          report_fault("unexpected result, total_bytes", 32'd0, total_bytes);
        end else begin
          want = chain_size_q.pop_front();
          if (total_bytes !== want.total)
            report_fault("total_bytes", want.total, total_bytes);
          if (bpp_out !== want.bpp)
            report_fault("bytes_per_texel", 32'(want.bpp), 32'(bpp_out));
          if (comps_out !== want.comps)
            report_fault("component_count", 32'(want.comps), 32'(comps_out));
        end
      end
      if (in_valid && in_ready) begin
        seen_desc.fmt    = fmt_code;
        seen_desc.w      = tex_w;
        seen_desc.h      = tex_h;
        seen_desc.d      = tex_d;
        seen_desc.levels = levels;
        chain_size_q.push_back(mip_chain_bytes(seen_desc));
        taken_n <= taken_n + 1;
      end
      backlog_n <= chain_size_q.size();
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
